FILE: src/vfp_pkg.sv
// ----------------------------------------------------------------------------
// vfp_pkg
// shared types and constants for the voltage frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package vfp_pkg;

    // ascii codes seen by the scanner
    localparam logic [7:0] CHAR_GT   = 8'h3E;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SP   = 8'h20;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // payload length limit and field widths
    localparam int unsigned CNT_W     = 3;
    localparam logic [2:0]  MAX_CHARS = 3'd7;
    localparam int unsigned INT_W     = 24;
    localparam int unsigned FRAC_W    = 10;
    localparam int unsigned MV_W      = 34;
    localparam int unsigned THR_W     = 16;
    localparam int unsigned LIM_W     = 20;

    // register map, indexed by paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_LIMIT     = 1'b1;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd10;
    localparam logic [LIM_W-1:0] LIMIT_RESET     = 20'd37000;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_ONE,
        PH_PAYLOAD
    } frame_phase_t;

    typedef enum logic [1:0] {
        DG_INT,
        DG_FRAC,
        DG_DONE
    } digit_phase_t;

    // frame end event from the scanner
    typedef struct packed {
        logic [INT_W-1:0]  int_val;
        logic [FRAC_W-1:0] frac_mv;
    } frame_end_t;

    // one result word
    typedef struct packed {
        logic              over_voltage;
        logic              changed;
        logic [MV_W-1:0]   held_mv;
        logic [MV_W-1:0]   parsed_mv;
    } result_t;

endpackage

`default_nettype wire

FILE: src/vfp_scan.sv
// ----------------------------------------------------------------------------
// vfp_scan
// byte scanner: prefix hunt, payload digit parse, frame end event register
// ----------------------------------------------------------------------------
`default_nettype none

module vfp_scan (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          in_byte,
    output logic                     ev_valid,
    input  wire logic                ev_ready,
    output vfp_pkg::frame_end_t      ev
);

    vfp_pkg::frame_phase_t             phase_reg, phase_next;
    vfp_pkg::digit_phase_t             dphase_reg, dphase_next;
    logic [vfp_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [vfp_pkg::INT_W-1:0]         int_reg, int_next;
    logic [vfp_pkg::FRAC_W-1:0]        frac_reg, frac_next;
    logic [1:0]                        fdig_reg, fdig_next;
    logic                              ev_valid_reg, ev_valid_next;
    vfp_pkg::frame_end_t               ev_reg, ev_next;
    logic [vfp_pkg::FRAC_W-1:0]        frac_scaled;
    logic                              fire;
    logic                              is_digit;
    logic [3:0]                        digit;

    assign in_ready = !ev_valid_reg || ev_ready;
    assign fire     = in_valid && in_ready;
    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

    assign is_digit = (in_byte >= vfp_pkg::CHAR_ZERO) && (in_byte <= vfp_pkg::CHAR_NINE);
    assign digit    = 4'(in_byte - vfp_pkg::CHAR_ZERO);

    // fraction padded out to three digits
    always_comb begin
        case (fdig_reg)
            2'd0:    frac_scaled = '0;
            2'd1:    frac_scaled = vfp_pkg::FRAC_W'(frac_reg * 10'd100);
            2'd2:    frac_scaled = vfp_pkg::FRAC_W'(frac_reg * 10'd10);
            default: frac_scaled = frac_reg;
        endcase
    end

    always_comb begin
        phase_next    = phase_reg;
        dphase_next   = dphase_reg;
        count_next    = count_reg;
        int_next      = int_reg;
        frac_next     = frac_reg;
        fdig_next     = fdig_reg;
        ev_next       = ev_reg;
        ev_valid_next = ev_valid_reg && !ev_ready;
        if (fire) begin
            unique case (phase_reg)
                vfp_pkg::PH_HUNT: begin
                    if (in_byte == vfp_pkg::CHAR_GT) phase_next = vfp_pkg::PH_ONE;
                end
                vfp_pkg::PH_ONE: begin
                    if (in_byte == vfp_pkg::CHAR_GT) begin
                        phase_next  = vfp_pkg::PH_PAYLOAD;
                        dphase_next = vfp_pkg::DG_INT;
                        count_next  = '0;
                        int_next    = '0;
                        frac_next   = '0;
                        fdig_next   = '0;
                    end else begin
                        phase_next = vfp_pkg::PH_HUNT;
                    end
                end
                vfp_pkg::PH_PAYLOAD: begin
                    if (in_byte == vfp_pkg::CHAR_CR || in_byte == vfp_pkg::CHAR_LF) begin
                        ev_valid_next   = 1'b1;
                        ev_next.int_val = int_reg;
                        ev_next.frac_mv = frac_scaled;
                        phase_next      = vfp_pkg::PH_HUNT;
                        dphase_next     = vfp_pkg::DG_INT;
                        count_next      = '0;
                        int_next        = '0;
                        frac_next       = '0;
                        fdig_next       = '0;
                    end else if (!(in_byte == vfp_pkg::CHAR_SP && count_reg == '0)
                                 && count_reg < vfp_pkg::MAX_CHARS) begin
                        count_next = count_reg + 1'b1;
                        case (dphase_reg)
                            vfp_pkg::DG_INT: begin
                                if (is_digit)
                                    int_next = vfp_pkg::INT_W'({int_reg, 3'b000})
                                             + vfp_pkg::INT_W'({int_reg, 1'b0})
                                             + vfp_pkg::INT_W'(digit);
                                else if (in_byte == vfp_pkg::CHAR_DOT)
                                    dphase_next = vfp_pkg::DG_FRAC;
                                else
                                    dphase_next = vfp_pkg::DG_DONE;
                            end
                            vfp_pkg::DG_FRAC: begin
                                if (is_digit) begin
                                    if (fdig_reg != 2'd3) begin
                                        frac_next = vfp_pkg::FRAC_W'(frac_reg * 10'd10)
                                                  + vfp_pkg::FRAC_W'(digit);
                                        fdig_next = fdig_reg + 1'b1;
                                    end
                                end else begin
                                    dphase_next = vfp_pkg::DG_DONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: phase_next = vfp_pkg::PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= vfp_pkg::PH_HUNT;
            dphase_reg   <= vfp_pkg::DG_INT;
            count_reg    <= '0;
            int_reg      <= '0;
            frac_reg     <= '0;
            fdig_reg     <= '0;
            ev_valid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            dphase_reg   <= dphase_next;
            count_reg    <= count_next;
            int_reg      <= int_next;
            frac_reg     <= frac_next;
            fdig_reg     <= fdig_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_reg <= ev_next;
    end

endmodule

`default_nettype wire

FILE: src/vfp_scale.sv
// ----------------------------------------------------------------------------
// vfp_scale
// converts a frame end event to millivolts, one register stage
// ----------------------------------------------------------------------------
`default_nettype none

module vfp_scale (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     ev_valid,
    output logic                          ev_ready,
    input  wire vfp_pkg::frame_end_t      ev,
    output logic                          mv_valid,
    input  wire logic                     mv_ready,
    output logic [vfp_pkg::MV_W-1:0]      mv
);

    logic                          valid_reg, valid_next;
    logic [vfp_pkg::MV_W-1:0]      mv_reg, mv_next;

    assign ev_ready = !valid_reg || mv_ready;
    assign mv_valid = valid_reg;
    assign mv       = mv_reg;

    always_comb begin
        valid_next = valid_reg && !mv_ready;
        mv_next    = mv_reg;
        if (ev_valid && ev_ready) begin
            valid_next = 1'b1;
            mv_next    = vfp_pkg::MV_W'(ev.int_val) * 34'd1000 + vfp_pkg::MV_W'(ev.frac_mv);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mv_reg <= mv_next;
    end

endmodule

`default_nettype wire

FILE: src/vfp_hold.sv
// ----------------------------------------------------------------------------
// vfp_hold
// held value update, over-voltage flag and result register
// ----------------------------------------------------------------------------
`default_nettype none

module vfp_hold (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      mv_valid,
    output logic                           mv_ready,
    input  wire logic [vfp_pkg::MV_W-1:0]  mv,
    input  wire logic [vfp_pkg::THR_W-1:0] threshold,
    input  wire logic [vfp_pkg::LIM_W-1:0] limit,
    output logic                           res_valid,
    input  wire logic                      res_ready,
    output vfp_pkg::result_t               res
);

    logic                          held_valid_reg, held_valid_next;
    logic [vfp_pkg::MV_W-1:0]      held_reg, held_next;
    logic                          valid_reg, valid_next;
    vfp_pkg::result_t              res_reg, res_next;
    logic [vfp_pkg::MV_W-1:0]      diff;
    logic                          replace;
    logic                          over_new, over_old;

    assign mv_ready  = !valid_reg || res_ready;
    assign res_valid = valid_reg;
    assign res       = res_reg;

    assign diff     = (mv >= held_reg) ? (mv - held_reg) : (held_reg - mv);
    assign replace  = !held_valid_reg || (diff > vfp_pkg::MV_W'(threshold));
    assign over_new = mv > vfp_pkg::MV_W'(limit);
    assign over_old = held_reg > vfp_pkg::MV_W'(limit);

    always_comb begin
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        valid_next      = valid_reg && !res_ready;
        res_next        = res_reg;
        if (mv_valid && mv_ready) begin
            valid_next            = 1'b1;
            res_next.parsed_mv    = mv;
            res_next.changed      = replace;
            if (replace) begin
                held_next             = mv;
                held_valid_next       = 1'b1;
                res_next.held_mv      = mv;
                res_next.over_voltage = over_new;
            end else begin
                res_next.held_mv      = held_reg;
                res_next.over_voltage = over_old;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_reg       <= '0;
            valid_reg      <= 1'b0;
        end else begin
            held_valid_reg <= held_valid_next;
            held_reg       <= held_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

FILE: src/voltage_frame_parser.sv
// ----------------------------------------------------------------------------
// voltage_frame_parser
// finds ">>" framed voltage text in a serial byte stream and reports millivolts
// ----------------------------------------------------------------------------
// throughput: one byte word per cycle, set by the per-byte scanner update, unless a frame end event waits
// output path: the cr/lf word that closes a frame reaches m_tvalid through
//   the scanner event register, the millivolt scaling register and the result register
// reset: synchronous active-low aresetn; the frame hunt restarts, the held
//   value is cleared and the registers return to threshold 10 mv, limit 37000 mv
`default_nettype none

module voltage_frame_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // byte input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [33:0] parsed_mv, [67:34] held_mv,
                                        // [68] changed, [69] over_voltage, [71:70] zero
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [vfp_pkg::THR_W-1:0]   threshold_reg, threshold_next;
    logic [vfp_pkg::LIM_W-1:0]   limit_reg, limit_next;
    logic                        cfg_write;

    logic                        ev_valid, ev_ready;
    vfp_pkg::frame_end_t         ev;
    logic                        mv_valid, mv_ready;
    logic [vfp_pkg::MV_W-1:0]    mv;
    vfp_pkg::result_t            res;

    // ------------------------------------------------------------------
    // register port: pready tied high, no wait states, registers decoded on paddr[2]
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        threshold_next = threshold_reg;
        limit_next     = limit_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                vfp_pkg::REG_THRESHOLD: threshold_next = pwdata[vfp_pkg::THR_W-1:0];
                vfp_pkg::REG_LIMIT:     limit_next     = pwdata[vfp_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            vfp_pkg::REG_THRESHOLD: prdata = 32'(threshold_reg);
            vfp_pkg::REG_LIMIT:     prdata = 32'(limit_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= vfp_pkg::THRESHOLD_RESET;
            limit_reg     <= vfp_pkg::LIMIT_RESET;
        end else begin
            threshold_reg <= threshold_next;
            limit_reg     <= limit_next;
        end
    end

    // ------------------------------------------------------------------
    // datapath: scanner -> millivolt scaling -> held value and result
    // each stage is elastic, so bytes flow on until events back up into the scanner while a result waits
    // ------------------------------------------------------------------
    vfp_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev       (ev)
    );

    vfp_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev       (ev),
        .mv_valid (mv_valid),
        .mv_ready (mv_ready),
        .mv       (mv)
    );

    vfp_hold u_hold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mv_valid  (mv_valid),
        .mv_ready  (mv_ready),
        .mv        (mv),
        .threshold (threshold_reg),
        .limit     (limit_reg),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // pack the result word, first field lowest
    assign m_tdata = {2'b00, res.over_voltage, res.changed, res.held_mv, res.parsed_mv};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a replaced held value is the value of this frame
    a_changed_held : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.changed) |-> (res.held_mv == res.parsed_mv))
        else $error("held value differs from parsed value on a change");

    // input only stalls while a frame end event is waiting
    a_stall_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> ev_valid)
        else $error("input stalled without a pending frame end");

    // a scaled value that waits keeps its content
    a_mv_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_valid && !mv_ready) |=> (mv_valid && $stable(mv)))
        else $error("stalled millivolt value changed");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// regression for the voltage frame parser: ">>" framed text in, millivolts out
// ----------------------------------------------------------------------------
// byte words go in on the s_ stream and result words come back on the m_ stream.
// a behavioural parser inside the bench follows every accepted byte and queues
// the result each frame end should give; results are checked field by field in
// order. a short directed table comes first, then six random segments, each
// with its own threshold and limit; pairs of segments share one of three stall patterns.
module testbench;

    localparam int unsigned SEG_BYTES    = 290;   // at least this many byte words per random segment
    localparam int unsigned DRAIN_CYCLES = 8;     // pipeline is 3 deep, with margin
    localparam int unsigned TAIL_CYCLES  = 20;    // quiet time before the verdict
    localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int unsigned STALL_LIMIT  = 5000;  // cycles with no word moving

    // ------------------------------------------------------------------------
    // clock, ports and the block
    // ------------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;    // [33:0] parsed_mv, [67:34] held_mv, [68] changed,
                             // [69] over_voltage, [71:70] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    voltage_frame_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    vfp_pkg::result_t pending_results [$];   // results still owed by the block, oldest first
    logic [7:0]  tx_bytes [$];          // bytes of the frame being sent
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_gap_pct = 11;     // chance in a hundred the sender idles
    int unsigned recv_gap_pct = 75;     // chance in a hundred the receiver stalls
    bit          long_hold_req = 1'b0;

    // shadow of the parser: frame scanner, number accumulators, held value
    vfp_pkg::frame_phase_t      scan_phase = vfp_pkg::PH_HUNT;
    vfp_pkg::digit_phase_t      dig_phase  = vfp_pkg::DG_INT;
    logic [vfp_pkg::CNT_W-1:0]  kept_chars = '0;
    logic [vfp_pkg::INT_W-1:0]  int_acc    = '0;
    logic [vfp_pkg::FRAC_W-1:0] frac_acc   = '0;
    logic [1:0]                 frac_cnt   = '0;
    logic [vfp_pkg::MV_W-1:0]   held       = '0;
    bit                         have_held  = 1'b0;
    logic [vfp_pkg::THR_W-1:0]  thr        = vfp_pkg::THRESHOLD_RESET;
    logic [vfp_pkg::LIM_W-1:0]  lim        = vfp_pkg::LIMIT_RESET;

    // ------------------------------------------------------------------------
    // parser shadow: one byte in, a result out at a frame end
    // ------------------------------------------------------------------------
    function automatic bit parse_byte(input logic [7:0] c, output vfp_pkg::result_t res);
        logic [vfp_pkg::MV_W-1:0] frac_mv;
        logic [vfp_pkg::MV_W-1:0] value_mv;
        logic [vfp_pkg::MV_W-1:0] gap;
        bit                       is_digit;
        int                       k;
        res = '0;
        is_digit = (c >= vfp_pkg::CHAR_ZERO) && (c <= vfp_pkg::CHAR_NINE);
        // prefix hunt: anything but the second '>' drops back to hunting
        if (scan_phase == vfp_pkg::PH_HUNT && c == vfp_pkg::CHAR_GT) begin
            scan_phase = vfp_pkg::PH_ONE;
            return 1'b0;
        end
        if (scan_phase == vfp_pkg::PH_ONE && c == vfp_pkg::CHAR_GT) begin
            scan_phase = vfp_pkg::PH_PAYLOAD;
            kept_chars = '0;
            dig_phase  = vfp_pkg::DG_INT;
            int_acc    = '0;
            frac_acc   = '0;
            frac_cnt   = '0;
            return 1'b0;
        end
        if (scan_phase != vfp_pkg::PH_PAYLOAD) begin
            scan_phase = vfp_pkg::PH_HUNT;
            return 1'b0;
        end
        // frame end: scale to millivolts and apply the hysteresis
        if (c == vfp_pkg::CHAR_CR || c == vfp_pkg::CHAR_LF) begin
            frac_mv = vfp_pkg::MV_W'(frac_acc);
            for (k = frac_cnt; k < 3; k++)
                frac_mv = frac_mv * 10;
            value_mv = vfp_pkg::MV_W'(int_acc) * vfp_pkg::MV_W'(1000) + frac_mv;
            gap = (value_mv >= held) ? value_mv - held : held - value_mv;
            res.changed = 1'b0;
            if (!have_held || gap > vfp_pkg::MV_W'(thr)) begin
                held        = value_mv;
                have_held   = 1'b1;
                res.changed = 1'b1;
            end
            res.parsed_mv    = value_mv;
            res.held_mv      = held;
            res.over_voltage = (held > vfp_pkg::MV_W'(lim));
            scan_phase = vfp_pkg::PH_HUNT;
            kept_chars = '0;
            dig_phase  = vfp_pkg::DG_INT;
            int_acc    = '0;
            frac_acc   = '0;
            frac_cnt   = '0;
            return 1'b1;
        end
        // leading spaces are skipped, characters past the limit are dropped
        if (c == vfp_pkg::CHAR_SP && kept_chars == 0)
            return 1'b0;
        if (kept_chars < vfp_pkg::MAX_CHARS) begin
            kept_chars++;
            case (dig_phase)
                vfp_pkg::DG_INT: begin
                    if (is_digit)
                        int_acc = vfp_pkg::INT_W'(int_acc * 10
                                  + vfp_pkg::INT_W'(c - vfp_pkg::CHAR_ZERO));
                    else if (c == vfp_pkg::CHAR_DOT)
                        dig_phase = vfp_pkg::DG_FRAC;
                    else
                        dig_phase = vfp_pkg::DG_DONE;
                end
                vfp_pkg::DG_FRAC: begin
                    if (is_digit) begin
                        // digits past the third are truncated
                        if (frac_cnt < 3) begin
                            frac_acc = vfp_pkg::FRAC_W'(frac_acc * 10
                                       + vfp_pkg::FRAC_W'(c - vfp_pkg::CHAR_ZERO));
                            frac_cnt++;
                        end
                    end else begin
                        dig_phase = vfp_pkg::DG_DONE;
                    end
                end
                default: ;
            endcase
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // random frame builder, appends one frame (or some noise) to tx_bytes
    // ------------------------------------------------------------------------
    function automatic void queue_frame();
        int unsigned              kind;
        int unsigned              n;
        int unsigned              off;
        logic [vfp_pkg::MV_W-1:0] target;
        string                    txt;
        kind = $urandom_range(99);
        // plain noise over the whole byte range
        if (kind < 8) begin
            repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        // broken prefix
        if (kind < 14) begin
            tx_bytes.push_back(vfp_pkg::CHAR_GT);
            tx_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        tx_bytes.push_back(vfp_pkg::CHAR_GT);
        tx_bytes.push_back(vfp_pkg::CHAR_GT);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) tx_bytes.push_back(vfp_pkg::CHAR_SP);
        if (kind < 50) begin
            // a value close to the held one or to the over-voltage limit, so
            // the threshold and the limit compares get hit on both sides
            if (kind < 38) begin
                off    = $urandom_range(0, int'(thr) + 2);
                target = held;
            end else begin
                off    = $urandom_range(0, 20);
                target = vfp_pkg::MV_W'(lim);
            end
            if ($urandom_range(1))
                target = target + off;
            else
                target = (off > target) ? '0 : target - off;
            txt = $sformatf("%0d.%03d", target / 1000, target % 1000);
            foreach (txt[i]) tx_bytes.push_back(txt[i]);
        end else if (kind < 54) begin
            repeat (7) tx_bytes.push_back(vfp_pkg::CHAR_NINE);
        end else begin
            n = ($urandom_range(3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 2);
            repeat (n) tx_bytes.push_back(vfp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(1)) begin
                tx_bytes.push_back(vfp_pkg::CHAR_DOT);
                repeat ($urandom_range(0, 5))
                    tx_bytes.push_back(vfp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
            end
            if ($urandom_range(5) == 0)
                tx_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
        // most frames close, a few run on into the next one
        if (kind < 97)
            tx_bytes.push_back($urandom_range(1) ? vfp_pkg::CHAR_CR : vfp_pkg::CHAR_LF);
    endfunction

    // ------------------------------------------------------------------------
    // sender: one byte word, driven at the falling edge, taken at the rising
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] value, output bit ended,
                             output vfp_pkg::result_t res);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        ended = parse_byte(value, res);
        @(negedge aclk);
    endtask

    // register write followed by a read-back of the same register
    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] want;
        want = (reg_sel == vfp_pkg::REG_THRESHOLD) ? 32'(value[vfp_pkg::THR_W-1:0])
                                                   : 32'(value[vfp_pkg::LIM_W-1:0]);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (reg_sel == vfp_pkg::REG_THRESHOLD)
            thr = value[vfp_pkg::THR_W-1:0];
        else
            lim = value[vfp_pkg::LIM_W-1:0];
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== want) begin
            mismatches++;
            $display("%0t: register %0d read back, expected %0d, actual %0d",
                     $time, reg_sel, want, readback);
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name,
                                        input logic [vfp_pkg::MV_W-1:0] want,
                                        input logic [vfp_pkg::MV_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        vfp_pkg::result_t got;
        vfp_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[69:0];
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected, actual parsed_mv %0d",
                         $time, got.parsed_mv);
            end else begin
                want = pending_results.pop_front();
                check_field("parsed_mv", want.parsed_mv, got.parsed_mv);
                check_field("held_mv", want.held_mv, got.held_mv);
                check_field("changed", vfp_pkg::MV_W'(want.changed),
                            vfp_pkg::MV_W'(got.changed));
                check_field("over_voltage", vfp_pkg::MV_W'(want.over_voltage),
                            vfp_pkg::MV_W'(got.over_voltage));
            end
        end
    end

    // watchdog: ends the run when no word moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("voltage_frame_parser regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // directed table, run on the reset settings (threshold 10, limit 37000)
    // ------------------------------------------------------------------------
    typedef struct {
        string                    text;        // bytes sent first
        logic [7:0]               tail;        // closing byte, always sent
        bit                       typed;       // result below is the one to check
        logic [vfp_pkg::MV_W-1:0] exp_parsed;
        logic [vfp_pkg::MV_W-1:0] exp_held;
        bit                       exp_changed;
        bit                       exp_over;
    } row_t;

    row_t directed_rows [21] = '{
        // first value is always taken
        '{">>12.5",       vfp_pkg::CHAR_CR, 1'b1, 34'd12500, 34'd12500, 1'b1, 1'b0},
        // difference of 9 stays under the threshold
        '{">>12.509",     vfp_pkg::CHAR_LF, 1'b1, 34'd12509, 34'd12500, 1'b0, 1'b0},
        // difference of 11 replaces the held value
        '{">>12.511",     vfp_pkg::CHAR_CR, 1'b1, 34'd12511, 34'd12511, 1'b1, 1'b0},
        // leading spaces, held just above the limit
        '{">>  37.001",   vfp_pkg::CHAR_CR, 1'b1, 34'd37001, 34'd37001, 1'b1, 1'b1},
        '{">>37.0",       vfp_pkg::CHAR_CR, 1'b1, 34'd37000, 34'd37001, 1'b0, 1'b1},
        // prefix broken, cr and lf outside a frame, top byte value
        '{">x>5",         vfp_pkg::CHAR_CR, 1'b0, '0, '0, 1'b0, 1'b0},
        '{">",            vfp_pkg::CHAR_LF, 1'b0, '0, '0, 1'b0, 1'b0},
        '{">",            8'hFF,            1'b0, '0, '0, 1'b0, 1'b0},
        // payload longer than the kept characters
        '{">>1234567890", vfp_pkg::CHAR_CR, 1'b1, 34'd1234567000, 34'd1234567000, 1'b1, 1'b1},
        // empty and non-numeric payloads read as zero
        '{">>",           vfp_pkg::CHAR_CR, 1'b1, 34'd0,     34'd0,     1'b1, 1'b0},
        '{">>abc",        vfp_pkg::CHAR_LF, 1'b1, 34'd0,     34'd0,     1'b0, 1'b0},
        // fraction digits past the third are truncated
        '{">>1.23456",    vfp_pkg::CHAR_CR, 1'b1, 34'd1234,  34'd1234,  1'b1, 1'b0},
        // '>' inside the payload is an ordinary character
        '{">>>>5",        vfp_pkg::CHAR_CR, 1'b0, '0, '0, 1'b0, 1'b0},
        '{">>7>",         vfp_pkg::CHAR_LF, 1'b0, '0, '0, 1'b0, 1'b0},
        // largest value the kept characters can hold
        '{">>9999999",    vfp_pkg::CHAR_CR, 1'b1, 34'd9999999000, 34'd9999999000, 1'b1, 1'b1},
        '{">>.5",         vfp_pkg::CHAR_CR, 1'b0, '0, '0, 1'b0, 1'b0},
        '{">> 0.999 2",   vfp_pkg::CHAR_LF, 1'b0, '0, '0, 1'b0, 1'b0},
        // zero byte in the payload, frame closed in the next row
        '{">>",           8'h00,            1'b0, '0, '0, 1'b0, 1'b0},
        '{"9",            vfp_pkg::CHAR_LF, 1'b0, '0, '0, 1'b0, 1'b0},
        '{">>12.3.4",     vfp_pkg::CHAR_CR, 1'b0, '0, '0, 1'b0, 1'b0},
        '{">>1.2345678",  vfp_pkg::CHAR_CR, 1'b0, '0, '0, 1'b0, 1'b0}
    };

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        vfp_pkg::result_t          res;
        bit                        ended;
        logic [7:0]                b;
        int                        j;
        int unsigned               sent;
        logic [vfp_pkg::THR_W-1:0] next_thr;
        logic [vfp_pkg::LIM_W-1:0] next_lim;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed rows: typed results where given, the shadow parser otherwise
        foreach (directed_rows[i]) begin
            for (j = 0; j <= directed_rows[i].text.len(); j++) begin
                b = (j < directed_rows[i].text.len()) ? directed_rows[i].text[j]
                                                       : directed_rows[i].tail;
                send_byte(b, ended, res);
                if (ended && directed_rows[i].typed && j == directed_rows[i].text.len()) begin
                    res.parsed_mv    = directed_rows[i].exp_parsed;
                    res.held_mv      = directed_rows[i].exp_held;
                    res.changed      = directed_rows[i].exp_changed;
                    res.over_voltage = directed_rows[i].exp_over;
                end
                if (ended)
                    pending_results.push_back(res);
            end
        end
        s_tvalid <= 1'b0;

        // random segments: new settings once the block has gone quiet
        for (int seg = 0; seg < 6; seg++) begin
            while (pending_results.size() != 0) @(negedge aclk);
            repeat (DRAIN_CYCLES) @(negedge aclk);
            case (seg)
                0:       begin next_thr = '0;       next_lim = 20'd1000000; end
                1:       begin next_thr = '1;       next_lim = '0;          end
                3:       begin next_thr = '0;       next_lim = '0;          end
                4:       begin next_thr = '1;       next_lim = 20'd1000000; end
                default: begin
                    next_thr = vfp_pkg::THR_W'($urandom_range(0, 65535));
                    next_lim = vfp_pkg::LIM_W'($urandom_range(0, 1000000));
                end
            endcase
            write_register(vfp_pkg::REG_THRESHOLD, 32'(next_thr));
            write_register(vfp_pkg::REG_LIMIT, 32'(next_lim));

            // stall pattern: slow receiver, then slow sender, then flat out
            case (seg / 2)
                0:       begin send_gap_pct = 11; recv_gap_pct = 75; end
                1:       begin send_gap_pct = 75; recv_gap_pct = 11; end
                default: begin send_gap_pct = 0;  recv_gap_pct = 0;  end
            endcase

            sent = 0;
            while (sent < SEG_BYTES) begin
                queue_frame();
                while (tx_bytes.size() != 0) begin
                    b = tx_bytes.pop_front();
                    send_byte(b, ended, res);
                    if (ended)
                        pending_results.push_back(res);
                    sent++;
                    // flat-out segment: hold the receiver off so the block backs up
                    if (seg == 4 && sent == 100)
                        long_hold_req = 1'b1;
                end
            end
            s_tvalid <= 1'b0;
        end

        while (pending_results.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0)
            $display("voltage_frame_parser regression: pass");
        else
            $display("voltage_frame_parser regression: fail");
        $finish;
    end

endmodule
